// ===== rtl/core/tna_pkg.sv =====
// Shared types, sizes and helpers for the threshold neighbour automaton step.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tna_pkg;

   // Grid limits and the widths that follow from them.
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);

   // Fixed field widths of the ports.
   localparam int SIZE_W     = 11;
   localparam int THR_W      = 9;
   localparam int NEED_W     = 3;
   localparam int VALUE_W    = 8;
   localparam int RES_ROW_W  = 10;
   localparam int RES_COL_W  = 10;

   // Queue between the classifying front and the emitting back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Result slots of one item, in the order they leave the block.
   localparam int SLOTS      = 3;
   localparam int SLOT_UP    = 0;   // cell one row above the item
   localparam int SLOT_LEFT  = 1;   // cell left of the item, last row only
   localparam int SLOT_SELF  = 2;   // the item's own cell, last cell only

   typedef struct packed {
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
      logic [THR_W-1:0]  threshold;
      logic [NEED_W-1:0] needed;
   } tna_cfg_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [SLOTS-1:0] valid;
      logic [SLOTS-1:0] flag;
   } tna_item_type;

   // A size of zero acts as one, a size above the maximum as the maximum.
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] mx);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > mx) begin
         r = mx;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tna_line_ram.sv =====
// Line buffer of two qualify bits per column: one write port, two read ports
// with registered read data. Depends on tna_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none

module tna_line_ram (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [tna_pkg::COL_W-1:0] wr_addr,
   input  wire logic [1:0]               wr_data,
   input  wire logic [tna_pkg::COL_W-1:0] rd_addr_a,
   input  wire logic [tna_pkg::COL_W-1:0] rd_addr_b,
   output logic      [1:0]               rd_data_a_ff,
   output logic      [1:0]               rd_data_b_ff
);

   logic [1:0] line_mem_ff [tna_pkg::MAX_WIDTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= line_mem_ff[rd_addr_a];
      rd_data_b_ff <= line_mem_ff[rd_addr_b];
   end

endmodule

`default_nettype wire

// ===== rtl/core/tna_front.sv =====
// Front part: accepts cells, tracks the raster position, keeps the line
// buffers and works out which results each item gives. Uses tna_pkg and tna_line_ram.
`timescale 1ns / 1ps
`default_nettype none

module tna_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tna_pkg::tna_cfg_type          cfg,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [tna_pkg::VALUE_W-1:0]   req_cell_value,
   input  wire logic                          req_cell_enabled,
   input  wire logic                          req_cell_flag,
   input  wire logic [tna_pkg::QCNT_W-1:0]    q_count,
   output logic                               push,
   output tna_pkg::tna_item_type              push_item
);

   typedef struct packed {
      logic                      valid;
      logic [tna_pkg::ROW_W-1:0] row;
      logic [tna_pkg::COL_W-1:0] col;
      logic                      q;
      logic                      row_gt0;
      logic                      row_gt1;
      logic                      col_gt0;
      logic                      col_ge2;
      logic                      has_right;
      logic                      row_end;
      logic                      last_row;
   } tna_s1_type;

   typedef struct packed {
      logic                      valid;
      logic [tna_pkg::COL_W-1:0] addr;
      logic [1:0]                data;
   } tna_wr_type;

   logic [tna_pkg::SIZE_W-1:0] w_eff;
   logic [tna_pkg::SIZE_W-1:0] h_eff;
   logic                       accept;
   logic [tna_pkg::COL_W-1:0]  cur_c;
   logic [tna_pkg::ROW_W-1:0]  cur_r;
   logic                       cur_right;
   logic                       cur_end;
   logic                       cur_last;
   logic                       cur_q;

   logic [tna_pkg::COL_W-1:0]  col_ff, col_in;
   logic [tna_pkg::ROW_W-1:0]  row_ff, row_in;
   tna_s1_type                 s1_ff, s1_in;
   tna_wr_type                 wr_ff, wr_in;
   logic                       prev_ff, prev_in;

   logic [1:0]                 rd_a0, rd_a1, rd_b0, rd_b1;
   logic [tna_pkg::COL_W-1:0]  s1_right_addr, s1_left_addr, s1_left2_addr;
   logic [1:0]                 old_ent, right_ent, left_ent, left2_ent;
   logic [tna_pkg::NEED_W-1:0] cnt_up, cnt_left, cnt_self;
   logic [1:0]                 wr_data;

   // Returns the entry as it stands after the write done at the read edge.
   function automatic logic [1:0] fwd(input logic [1:0] rd,
                                      input logic [tna_pkg::COL_W-1:0] addr,
                                      input tna_wr_type wr);
      logic [1:0] r;
      r = (wr.valid && (wr.addr == addr)) ? wr.data : rd;
      return r;
   endfunction

   assign w_eff = tna_pkg::clamp_size(cfg.width,  tna_pkg::SIZE_W'(tna_pkg::MAX_WIDTH));
   assign h_eff = tna_pkg::clamp_size(cfg.height, tna_pkg::SIZE_W'(tna_pkg::MAX_HEIGHT));

   // Room is needed for the item in the second stage and the one taken now.
   assign req_stall = (q_count + tna_pkg::QCNT_W'(s1_ff.valid))
                      >= tna_pkg::QCNT_W'(tna_pkg::QUEUE_DEPTH);
   assign accept    = req_valid & ~req_stall;

   // A counter at or beyond a shrunken size acts as the last column or row.
   assign cur_c = (tna_pkg::SIZE_W'(col_ff) < w_eff) ? col_ff
                  : tna_pkg::COL_W'(w_eff - tna_pkg::SIZE_W'(1));
   assign cur_r = (tna_pkg::SIZE_W'(row_ff) < h_eff) ? row_ff
                  : tna_pkg::ROW_W'(h_eff - tna_pkg::SIZE_W'(1));
   assign cur_right = (tna_pkg::SIZE_W'(cur_c) + tna_pkg::SIZE_W'(1)) < w_eff;
   assign cur_end   = tna_pkg::SIZE_W'(cur_c) == (w_eff - tna_pkg::SIZE_W'(1));
   assign cur_last  = tna_pkg::SIZE_W'(cur_r) == (h_eff - tna_pkg::SIZE_W'(1));
   assign cur_q     = req_cell_enabled & req_cell_flag
                      & (tna_pkg::THR_W'(req_cell_value) < cfg.threshold);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (cur_right) begin
            col_in = cur_c + tna_pkg::COL_W'(1);
            row_in = cur_r;
         end else begin
            col_in = '0;
            row_in = cur_last ? '0 : cur_r + tna_pkg::ROW_W'(1);
         end
      end
   end

   always_comb begin
      s1_in.valid     = accept;
      s1_in.row       = cur_r;
      s1_in.col       = cur_c;
      s1_in.q         = cur_q;
      s1_in.row_gt0   = cur_r != '0;
      s1_in.row_gt1   = cur_r > tna_pkg::ROW_W'(1);
      s1_in.col_gt0   = cur_c != '0;
      s1_in.col_ge2   = cur_c > tna_pkg::COL_W'(1);
      s1_in.has_right = cur_right;
      s1_in.row_end   = cur_end;
      s1_in.last_row  = cur_last;
   end

   // Copy a reads this column and the next, copy b the two to the left.
   tna_line_ram u_line_a (
      .clock        (clock),
      .wr_en        (s1_ff.valid),
      .wr_addr      (s1_ff.col),
      .wr_data      (wr_data),
      .rd_addr_a    (cur_c),
      .rd_addr_b    (cur_c + tna_pkg::COL_W'(1)),
      .rd_data_a_ff (rd_a0),
      .rd_data_b_ff (rd_a1)
   );

   tna_line_ram u_line_b (
      .clock        (clock),
      .wr_en        (s1_ff.valid),
      .wr_addr      (s1_ff.col),
      .wr_data      (wr_data),
      .rd_addr_a    (cur_c - tna_pkg::COL_W'(1)),
      .rd_addr_b    (cur_c - tna_pkg::COL_W'(2)),
      .rd_data_a_ff (rd_b0),
      .rd_data_b_ff (rd_b1)
   );

   assign s1_right_addr = s1_ff.col + tna_pkg::COL_W'(1);
   assign s1_left_addr  = s1_ff.col - tna_pkg::COL_W'(1);
   assign s1_left2_addr = s1_ff.col - tna_pkg::COL_W'(2);

   assign old_ent   = fwd(rd_a0, s1_ff.col,     wr_ff);
   assign right_ent = fwd(rd_a1, s1_right_addr, wr_ff);
   assign left_ent  = fwd(rd_b0, s1_left_addr,  wr_ff);
   assign left2_ent = fwd(rd_b1, s1_left2_addr, wr_ff);

   // Bit 0 of an entry is the newer row, bit 1 the older one.
   assign wr_data = {old_ent[0], s1_ff.q};

   assign cnt_up   = tna_pkg::NEED_W'(s1_ff.q)
                   + tna_pkg::NEED_W'(s1_ff.row_gt1 & old_ent[1])
                   + tna_pkg::NEED_W'(s1_ff.col_gt0 & prev_ff)
                   + tna_pkg::NEED_W'(s1_ff.has_right & right_ent[0]);
   assign cnt_left = tna_pkg::NEED_W'(s1_ff.q)
                   + tna_pkg::NEED_W'(s1_ff.row_gt0 & left_ent[1])
                   + tna_pkg::NEED_W'(s1_ff.col_ge2 & left2_ent[0]);
   assign cnt_self = tna_pkg::NEED_W'(s1_ff.row_gt0 & old_ent[0])
                   + tna_pkg::NEED_W'(s1_ff.col_gt0 & left_ent[0]);

   always_comb begin
      push_item.row = s1_ff.row;
      push_item.col = s1_ff.col;
      push_item.valid[tna_pkg::SLOT_UP]   = s1_ff.row_gt0;
      push_item.valid[tna_pkg::SLOT_LEFT] = s1_ff.last_row & s1_ff.col_gt0;
      push_item.valid[tna_pkg::SLOT_SELF] = s1_ff.last_row & s1_ff.row_end;
      push_item.flag[tna_pkg::SLOT_UP]    = old_ent[0]  & (cnt_up   >= cfg.needed);
      push_item.flag[tna_pkg::SLOT_LEFT]  = left_ent[0] & (cnt_left >= cfg.needed);
      push_item.flag[tna_pkg::SLOT_SELF]  = s1_ff.q     & (cnt_self >= cfg.needed);
   end

   assign push = s1_ff.valid & (|push_item.valid);

   always_comb begin
      wr_in.valid = s1_ff.valid;
      wr_in.addr  = s1_ff.col;
      wr_in.data  = wr_data;
      prev_in     = s1_ff.valid ? old_ent[0] : prev_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         prev_ff     <= 1'b0;
         s1_ff.valid <= 1'b0;
         wr_ff.valid <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         prev_ff     <= prev_in;
         s1_ff.valid <= s1_in.valid;
         wr_ff.valid <= wr_in.valid;
      end
      s1_ff.row       <= s1_in.row;
      s1_ff.col       <= s1_in.col;
      s1_ff.q         <= s1_in.q;
      s1_ff.row_gt0   <= s1_in.row_gt0;
      s1_ff.row_gt1   <= s1_in.row_gt1;
      s1_ff.col_gt0   <= s1_in.col_gt0;
      s1_ff.col_ge2   <= s1_in.col_ge2;
      s1_ff.has_right <= s1_in.has_right;
      s1_ff.row_end   <= s1_in.row_end;
      s1_ff.last_row  <= s1_in.last_row;
      wr_ff.addr      <= wr_in.addr;
      wr_ff.data      <= wr_in.data;
   end

endmodule

`default_nettype wire

// ===== rtl/core/tna_queue.sv =====
// Short queue of classified items between the front and the back part.
// Depends on tna_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none

module tna_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire tna_pkg::tna_item_type      push_item,
   input  wire logic                       pop,
   output tna_pkg::tna_item_type           head,
   output logic [tna_pkg::QCNT_W-1:0]      count
);

   tna_pkg::tna_item_type           mem_ff [tna_pkg::QUEUE_DEPTH];
   logic [tna_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tna_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tna_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign head  = mem_ff[rd_ptr_ff];
   assign count = count_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + tna_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + tna_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + tna_pkg::QCNT_W'(push) - tna_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/tna_back.sv =====
// Back part: takes items from the queue and sends their results one per
// cycle unless stalled, through the output register. Depends on tna_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tna_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tna_pkg::tna_item_type         head,
   input  wire logic [tna_pkg::QCNT_W-1:0]    q_count,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [tna_pkg::RES_ROW_W-1:0]      rsp_result_row,
   output logic [tna_pkg::RES_COL_W-1:0]      rsp_result_col,
   output logic                               rsp_next_flag,
   output logic                               rsp_run_last
);

   logic [tna_pkg::SLOTS-1:0]      done_ff, done_in;
   logic [tna_pkg::SLOTS-1:0]      pend;
   logic [tna_pkg::SLOTS-1:0]      sel;
   logic                           more;
   logic                           out_free;
   logic                           load;
   logic                           valid_ff, valid_in;
   logic [tna_pkg::RES_ROW_W-1:0]  row_ff, row_in;
   logic [tna_pkg::RES_COL_W-1:0]  col_ff, col_in;
   logic                           flag_ff, flag_in;
   logic                           last_ff, last_in;

   // Results of the head item go out lowest slot first.
   assign pend     = head.valid & ~done_ff;
   assign sel      = pend & (~pend + tna_pkg::SLOTS'(1));
   assign more     = |(pend & ~sel);
   assign out_free = ~valid_ff | ~rsp_stall;
   assign load     = out_free & (q_count != '0);
   assign pop      = load & ~more;

   always_comb begin
      done_in  = done_ff;
      valid_in = valid_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      flag_in  = flag_ff;
      last_in  = last_ff;
      if (out_free) begin
         valid_in = load;
      end
      if (load) begin
         done_in = more ? (done_ff | sel) : '0;
         row_in  = sel[tna_pkg::SLOT_UP]
                   ? tna_pkg::RES_ROW_W'(head.row - tna_pkg::ROW_W'(1))
                   : tna_pkg::RES_ROW_W'(head.row);
         col_in  = sel[tna_pkg::SLOT_LEFT]
                   ? tna_pkg::RES_COL_W'(head.col - tna_pkg::COL_W'(1))
                   : tna_pkg::RES_COL_W'(head.col);
         flag_in = |(sel & head.flag);
         last_in = ~more;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
      row_ff  <= row_in;
      col_ff  <= col_in;
      flag_ff <= flag_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_result_row = row_ff;
   assign rsp_result_col = col_ff;
   assign rsp_next_flag  = flag_ff;
   assign rsp_run_last   = last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/threshold_neighbour_automaton_step.sv =====
// Top level of the threshold neighbour automaton step: configuration
// registers, front, queue and back. Depends on tna_pkg and all tna_ modules.
//
// Cells of the grid enter in raster order on the req_ channel, one item per
// clock when not stalled. A cell qualifies when it is enabled, flagged and its
// value is below value_threshold; its next flag is set when it qualifies and
// at least neighbours_needed of its in-grid up, left, down and right
// neighbours do. The item at (r, c) gives the result of (r-1, c); on the last
// row it also gives the result of (r, c-1), and the last cell of the grid its
// own result. run_last marks the final result of an item, so an item gives
// none, one, two or three results on the rsp_ channel.
// Results leave through the output register. The block takes one item per
// cycle when not stalled; on the last row the output channel, at one result
// per cycle, sets the rate. A four-item queue lies between the front and the
// back part, and req_stall rises when it and the item in the front's second
// stage fill it; while rsp_stall is high the output holds.
// Reset sets the registers to their defaults and the position to row 0,
// column 0. The line buffers are not cleared: each column is written before
// it is read within a grid, so the block takes items from the first cycle.
// Write the csr_ registers only while no result is outstanding.
`timescale 1ns / 1ps
`default_nettype none

module threshold_neighbour_automaton_step (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [1:0]                   csr_index,
   input  wire logic [tna_pkg::SIZE_W-1:0]   csr_wdata,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [tna_pkg::VALUE_W-1:0]  req_cell_value,
   input  wire logic                         req_cell_enabled,
   input  wire logic                         req_cell_flag,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [tna_pkg::RES_ROW_W-1:0]     rsp_result_row,
   output logic [tna_pkg::RES_COL_W-1:0]     rsp_result_col,
   output logic                              rsp_next_flag,
   output logic                              rsp_run_last
);

   localparam logic [1:0] CSR_GRID_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_GRID_HEIGHT  = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD    = 2'd2;
   localparam logic [1:0] CSR_NEEDED       = 2'd3;

   tna_pkg::tna_cfg_type             cfg_ff, cfg_in;
   logic                             push;
   logic                             pop;
   tna_pkg::tna_item_type            push_item;
   tna_pkg::tna_item_type            head;
   logic [tna_pkg::QCNT_W-1:0]       q_count;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  cfg_in.width     = csr_wdata;
            CSR_GRID_HEIGHT: cfg_in.height    = csr_wdata;
            CSR_THRESHOLD:   cfg_in.threshold = csr_wdata[tna_pkg::THR_W-1:0];
            CSR_NEEDED:      cfg_in.needed    = csr_wdata[tna_pkg::NEED_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width     <= tna_pkg::SIZE_W'(1024);
         cfg_ff.height    <= tna_pkg::SIZE_W'(1024);
         cfg_ff.threshold <= tna_pkg::THR_W'(128);
         cfg_ff.needed    <= tna_pkg::NEED_W'(2);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tna_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cell_value   (req_cell_value),
      .req_cell_enabled (req_cell_enabled),
      .req_cell_flag    (req_cell_flag),
      .q_count          (q_count),
      .push             (push),
      .push_item        (push_item)
   );

   tna_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .count     (q_count)
   );

   tna_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_count        (q_count),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_result_row (rsp_result_row),
      .rsp_result_col (rsp_result_col),
      .rsp_next_flag  (rsp_next_flag),
      .rsp_run_last   (rsp_run_last)
   );

   // The stall logic must keep the queue from ever overfilling.
   assert property (@(posedge clock) disable iff (reset)
      q_count <= tna_pkg::QCNT_W'(tna_pkg::QUEUE_DEPTH))
      else $error("item queue holds more than its depth");

   // A full queue must hold off the input.
   assert property (@(posedge clock) disable iff (reset)
      (q_count == tna_pkg::QCNT_W'(tna_pkg::QUEUE_DEPTH)) |-> req_stall)
      else $error("input taken while the item queue is full");

   // Results only name cells inside the configured grid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (tna_pkg::SIZE_W'(rsp_result_col)
                     < tna_pkg::clamp_size(cfg_ff.width,
                                           tna_pkg::SIZE_W'(tna_pkg::MAX_WIDTH))))
      else $error("result column outside the grid");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (tna_pkg::SIZE_W'(rsp_result_row)
                     < tna_pkg::clamp_size(cfg_ff.height,
                                           tna_pkg::SIZE_W'(tna_pkg::MAX_HEIGHT))))
      else $error("result row outside the grid");

endmodule

`default_nettype wire

// ===== tb/tb_threshold_neighbour_automaton_step.sv =====
// Self-checking testbench for threshold_neighbour_automaton_step: a directed table, full-size
// and random grids, each result checked against the table or a cycle-free predictor of the generation.
// Depends only on tna_pkg and the block itself.
`timescale 1ns / 1ps

module tb_threshold_neighbour_automaton_step;
   import tna_pkg::*;

   localparam int SETTLE_CYCLES = 12;    // output register latency plus the item queue
   localparam int HOLD_CYCLES   = 80;
   localparam int RANDOM_CELLS  = 200;
   localparam int REPORT_LIMIT  = 10;

   typedef enum logic [1:0] {CSR_WIDTH, CSR_HEIGHT, CSR_THRESHOLD, CSR_NEEDED} csr_index_t;
   typedef enum logic [1:0] {CHECK_MODEL, EXPECT_NONE, EXPECT_ONE} check_mode_t;
   typedef enum logic {ROW_CELL, ROW_CSR} row_kind_t;

   typedef struct packed {
      logic [RES_ROW_W-1:0] row;
      logic [RES_COL_W-1:0] col;
      logic                 flag;
      logic                 last;
   } flag_result_t;

   typedef struct packed {
      row_kind_t         kind;
      csr_index_t        index;
      logic [SIZE_W-1:0] data;
      logic [VALUE_W-1:0] value;
      logic              enabled;
      logic              flagged;
      check_mode_t       mode;
      flag_result_t      want;
   } step_row_t;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [1:0]            csr_index;
   logic [SIZE_W-1:0]     csr_wdata;
   logic                  req_valid;
   logic                  req_stall;
   logic [VALUE_W-1:0]    req_cell_value;
   logic                  req_cell_enabled;
   logic                  req_cell_flag;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [RES_ROW_W-1:0]  rsp_result_row;
   logic [RES_COL_W-1:0]  rsp_result_col;
   logic                  rsp_next_flag;
   logic                  rsp_run_last;

   threshold_neighbour_automaton_step dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cell_value   (req_cell_value),
      .req_cell_enabled (req_cell_enabled),
      .req_cell_flag    (req_cell_flag),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_row   (rsp_result_row),
      .rsp_result_col   (rsp_result_col),
      .rsp_next_flag    (rsp_next_flag),
      .rsp_run_last     (rsp_run_last)
   );

   // Predictor state: its own copy of the registers, the two qualify rows and the position.
   logic [SIZE_W-1:0]  cfg_width     = 11'd1024;
   logic [SIZE_W-1:0]  cfg_height    = 11'd1024;
   logic [THR_W-1:0]   cfg_threshold = 9'd128;
   logic [NEED_W-1:0]  cfg_needed    = 3'd2;
   bit [1:0]           line_q [MAX_WIDTH];
   int unsigned        row_pos = 0;
   int unsigned        col_pos = 0;
   bit                 left_above = 1'b0;

   flag_result_t       fresh_results [$];
   flag_result_t       pending_flags [$];
   step_row_t          directed_steps [$];

   int  mismatch_count  = 0;
   int  results_checked = 0;
   int  cells_directed  = 0;
   int  cells_large     = 0;
   int  cells_random    = 0;
   int  csr_writes      = 0;
   bit  hold_req        = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #25_000_000;
      $display("Timeout with %0d results still outstanding", pending_flags.size());
      $display("Some tests failed");
      $finish;
   end

   function automatic int unsigned effective_size(input logic [SIZE_W-1:0] v, input int unsigned mx);
      if (v == 0) return 1;
      if (v > mx) return mx;
      return v;
   endfunction

   function automatic void add_result(input int unsigned r, input int unsigned c, input bit self,
                                      input int unsigned cnt);
      flag_result_t x;
      x.row  = RES_ROW_W'(r);
      x.col  = RES_COL_W'(c);
      x.flag = self && (cnt >= cfg_needed);
      x.last = 1'b0;
      fresh_results.push_back(x);
   endfunction

   // One cell of the raster stream: updates the line buffer and position, and leaves the
   // results that this cell releases in fresh_results.
   function automatic void predict_cell(input logic [VALUE_W-1:0] value, input logic en,
                                        input logic flg);
      int unsigned  w, h, r, c, cnt;
      bit           q;
      bit [1:0]     old, e;
      flag_result_t tail;
      w = effective_size(cfg_width, MAX_WIDTH);
      h = effective_size(cfg_height, MAX_HEIGHT);
      r = (row_pos < h) ? row_pos : h - 1;
      c = (col_pos < w) ? col_pos : w - 1;
      q = en && flg && ({1'b0, value} < cfg_threshold);
      old = line_q[c];
      fresh_results.delete();
      if (r > 0) begin
         cnt = q;
         if (r > 1) cnt += old[1];
         if (c > 0) cnt += left_above;
         if (c + 1 < w) cnt += line_q[c + 1][0];
         add_result(r - 1, c, old[0], cnt);
      end
      left_above = old[0];
      line_q[c] = {old[0], q};
      // The last row has no row below, so its cells are settled as soon as the right
      // neighbour has arrived.
      if (r == h - 1) begin
         if (c > 0) begin
            e = line_q[c - 1];
            cnt = q;
            if (r > 0) cnt += e[1];
            if (c >= 2) cnt += line_q[c - 2][0];
            add_result(r, c - 1, e[0], cnt);
         end
         if (c == w - 1) begin
            cnt = 0;
            if (r > 0) cnt += line_q[c][1];
            if (c > 0) cnt += line_q[c - 1][0];
            add_result(r, c, q, cnt);
         end
      end
      if (fresh_results.size() > 0) begin
         tail = fresh_results.pop_back();
         tail.last = 1'b1;
         fresh_results.push_back(tail);
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endfunction

   // Mostly no gap, sometimes a few cycles and now and then a long one.
   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 96) return $urandom_range(4, 12);
      return $urandom_range(25, 60);
   endfunction

   function automatic step_row_t csr_row(input csr_index_t idx, input logic [SIZE_W-1:0] data);
      step_row_t s;
      s = '0;
      s.kind  = ROW_CSR;
      s.index = idx;
      s.data  = data;
      return s;
   endfunction

   function automatic step_row_t cell_row(input logic [VALUE_W-1:0] v, input logic en,
                                          input logic flg, input check_mode_t mode,
                                          input logic [RES_ROW_W-1:0] r,
                                          input logic [RES_COL_W-1:0] c, input logic f);
      step_row_t s;
      s = '0;
      s.kind    = ROW_CELL;
      s.value   = v;
      s.enabled = en;
      s.flagged = flg;
      s.mode    = mode;
      s.want    = '{row: r, col: c, flag: f, last: 1'b1};
      return s;
   endfunction

   task automatic pause_sender(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic offer_cell(input logic [VALUE_W-1:0] v, input logic en, input logic flg,
                             input check_mode_t mode, input flag_result_t want);
      bit taken;
      req_valid        <= 1'b1;
      req_cell_value   <= v;
      req_cell_enabled <= en;
      req_cell_flag    <= flg;
      taken = 1'b0;
      // Inputs only move at rising edges, so the stall seen at the falling edge is the
      // one that decides the next rising edge.
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      predict_cell(v, en, flg);
      case (mode)
         CHECK_MODEL: foreach (fresh_results[i]) pending_flags.push_back(fresh_results[i]);
         EXPECT_ONE:  pending_flags.push_back(want);
         default: ;
      endcase
   endtask

   // Lowers valid and waits until every expected result has come and the pipeline is quiet.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_flags.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_t idx, input logic [SIZE_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_WIDTH:     cfg_width     = data;
         CSR_HEIGHT:    cfg_height    = data;
         CSR_THRESHOLD: cfg_threshold = data[THR_W-1:0];
         CSR_NEEDED:    cfg_needed    = data[NEED_W-1:0];
         default: ;
      endcase
      csr_writes++;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h,
                                input logic [SIZE_W-1:0] thr, input logic [SIZE_W-1:0] need);
      drain_results();
      write_csr(CSR_WIDTH, w);
      write_csr(CSR_HEIGHT, h);
      write_csr(CSR_THRESHOLD, thr);
      write_csr(CSR_NEEDED, need);
   endtask

   // Whole grids of random cells; most cells are enabled and flagged so that flags survive
   // long enough for the neighbour counts to matter.
   task automatic send_grids(input int grids, input bit calm, input bit pause_midway,
                             output int sent);
      int   total;
      logic en, flg;
      total = grids * effective_size(cfg_width, MAX_WIDTH) * effective_size(cfg_height, MAX_HEIGHT);
      for (int i = 0; i < total; i++) begin
         if (pause_midway && i == total / 2) drain_results();
         en  = ($urandom_range(0, 99) < 85) ? 1'b1 : 1'($urandom_range(0, 1));
         flg = ($urandom_range(0, 99) < 85) ? 1'b1 : 1'($urandom_range(0, 1));
         pause_sender(calm ? 0 : idle_len());
         offer_cell(VALUE_W'($urandom_range(0, 255)), en, flg, CHECK_MODEL, '0);
      end
      sent = total;
   endtask

   task automatic note_mismatch(input string what, input flag_result_t want,
                                input flag_result_t got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("Mismatch (%s): expected row %0d col %0d flag %0d last %0d, got row %0d col %0d flag %0d last %0d",
                  what, want.row, want.col, want.flag, want.last,
                  got.row, got.col, got.flag, got.last);
   endtask

   // Result checker: a result is taken at the next rising edge when valid is high and
   // stall low at the falling edge.
   always @(negedge clock) begin : check_results
      flag_result_t got, want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = '{row: rsp_result_row, col: rsp_result_col, flag: rsp_next_flag,
                 last: rsp_run_last};
         if (pending_flags.size() == 0) begin
            note_mismatch("no result expected", '0, got);
         end else begin
            want = pending_flags.pop_front();
            results_checked++;
            if (got.row !== want.row)   note_mismatch("row", want, got);
            if (got.col !== want.col)   note_mismatch("column", want, got);
            if (got.flag !== want.flag) note_mismatch("next flag", want, got);
            if (got.last !== want.last) note_mismatch("run last", want, got);
         end
      end
   end

   // Receiver: random stall and free stretches, plus one long hold when asked for.
   initial begin : receiver
      int remain;
      bit level;
      remain = 0;
      level  = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            level    = 1'b1;
            remain   = HOLD_CYCLES;
         end else if (remain == 0) begin
            if (!level) remain = idle_len();
            level = (remain != 0) && !level;
            if (!level) remain = ($urandom_range(0, 14) == 0) ? $urandom_range(30, 100)
                                                               : $urandom_range(1, 4);
         end
         rsp_stall <= level;
         remain--;
      end
   end

   initial begin : stimulus
      int                 sent, phase;
      logic [SIZE_W-1:0]  w, h, thr, need;
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_index        <= CSR_WIDTH;
      csr_wdata        <= '0;
      req_valid        <= 1'b0;
      req_cell_value   <= '0;
      req_cell_enabled <= 1'b0;
      req_cell_flag    <= 1'b0;
      foreach (line_q[i]) line_q[i] = 2'b00;

      // Row 0 of the default grid gives nothing; then the grid shrinks under the stream.
      directed_steps.push_back(cell_row(8'd10, 1'b1, 1'b1, EXPECT_NONE, 0, 0, 0));
      directed_steps.push_back(cell_row(8'd200, 1'b1, 1'b1, EXPECT_NONE, 0, 0, 0));
      directed_steps.push_back(cell_row(8'd0, 1'b0, 1'b1, EXPECT_NONE, 0, 0, 0));
      directed_steps.push_back(csr_row(CSR_HEIGHT, 11'd1));
      directed_steps.push_back(csr_row(CSR_WIDTH, 11'd4));
      directed_steps.push_back(cell_row(8'd5, 1'b1, 1'b1, CHECK_MODEL, 0, 0, 0));
      // Sizes of zero give a one-cell grid, whose single result needs no neighbours.
      directed_steps.push_back(csr_row(CSR_WIDTH, 11'd0));
      directed_steps.push_back(csr_row(CSR_HEIGHT, 11'd0));
      directed_steps.push_back(csr_row(CSR_THRESHOLD, 11'd256));
      directed_steps.push_back(csr_row(CSR_NEEDED, 11'd0));
      directed_steps.push_back(cell_row(8'd255, 1'b1, 1'b1, EXPECT_ONE, 0, 0, 1'b1));
      directed_steps.push_back(cell_row(8'd255, 1'b0, 1'b1, EXPECT_ONE, 0, 0, 1'b0));
      directed_steps.push_back(cell_row(8'd255, 1'b1, 1'b0, EXPECT_ONE, 0, 0, 1'b0));
      directed_steps.push_back(csr_row(CSR_THRESHOLD, 11'd0));
      directed_steps.push_back(cell_row(8'd0, 1'b1, 1'b1, EXPECT_ONE, 0, 0, 1'b0));
      directed_steps.push_back(csr_row(CSR_THRESHOLD, 11'd511));
      directed_steps.push_back(cell_row(8'd255, 1'b1, 1'b1, EXPECT_ONE, 0, 0, 1'b1));
      directed_steps.push_back(csr_row(CSR_NEEDED, 11'd7));
      directed_steps.push_back(cell_row(8'd0, 1'b1, 1'b1, EXPECT_ONE, 0, 0, 1'b0));
      directed_steps.push_back(csr_row(CSR_NEEDED, 11'd5));
      directed_steps.push_back(cell_row(8'd1, 1'b1, 1'b1, EXPECT_ONE, 0, 0, 1'b0));
      // A 3 by 3 grid with values either side of the threshold.
      directed_steps.push_back(csr_row(CSR_WIDTH, 11'd3));
      directed_steps.push_back(csr_row(CSR_HEIGHT, 11'd3));
      directed_steps.push_back(csr_row(CSR_THRESHOLD, 11'd128));
      directed_steps.push_back(csr_row(CSR_NEEDED, 11'd2));
      directed_steps.push_back(cell_row(8'd127, 1'b1, 1'b1, CHECK_MODEL, 0, 0, 0));
      directed_steps.push_back(cell_row(8'd0, 1'b1, 1'b1, CHECK_MODEL, 0, 0, 0));
      directed_steps.push_back(cell_row(8'd128, 1'b1, 1'b1, CHECK_MODEL, 0, 0, 0));
      directed_steps.push_back(cell_row(8'd3, 1'b1, 1'b1, CHECK_MODEL, 0, 0, 0));
      directed_steps.push_back(cell_row(8'd64, 1'b1, 1'b1, CHECK_MODEL, 0, 0, 0));
      directed_steps.push_back(cell_row(8'd90, 1'b1, 1'b1, CHECK_MODEL, 0, 0, 0));
      directed_steps.push_back(cell_row(8'd255, 1'b1, 1'b1, CHECK_MODEL, 0, 0, 0));
      directed_steps.push_back(cell_row(8'd1, 1'b1, 1'b1, CHECK_MODEL, 0, 0, 0));
      directed_steps.push_back(cell_row(8'd2, 1'b0, 1'b0, CHECK_MODEL, 0, 0, 0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == ROW_CSR) begin
            drain_results();
            write_csr(directed_steps[i].index, directed_steps[i].data);
         end else begin
            pause_sender(idle_len());
            offer_cell(directed_steps[i].value, directed_steps[i].enabled,
                       directed_steps[i].flagged, directed_steps[i].mode,
                       directed_steps[i].want);
            cells_directed++;
         end
      end

      // The widest and the tallest grid, with the upper register bits set.
      apply_setting(11'd2047, 11'd1, 11'd150, 11'd1);
      send_grids(1, 1'b0, 1'b0, sent);
      cells_large += sent;
      apply_setting(11'd1, 11'd2047, 11'h7FF, 11'h7FA);
      send_grids(1, 1'b0, 1'b0, sent);
      cells_large += sent;

      phase = 0;
      while (cells_random < RANDOM_CELLS) begin
         if (phase == 0) begin
            // The receiver holds off while items keep coming, so the block fills up.
            apply_setting(11'd8, 11'd6, 11'd200, 11'd2);
            hold_req = 1'b1;
            send_grids(1, 1'b1, 1'b0, sent);
         end else begin
            w    = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8) : $urandom_range(9, 40);
            h    = $urandom_range(0, 6);
            case ($urandom_range(0, 9))
               0:       thr = 11'd0;
               1:       thr = $urandom_range(256, 511);
               default: thr = $urandom_range(1, 255);
            endcase
            need = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4) : $urandom_range(5, 7);
            apply_setting(w, h, thr, need);
            send_grids($urandom_range(1, 2), $urandom_range(0, 3) == 0, phase == 1, sent);
         end
         cells_random += sent;
         phase++;
      end

      drain_results();
      mismatch_count += pending_flags.size();
      $display("Covered %0d directed, %0d full-size and %0d random cells over %0d register writes;",
               cells_directed, cells_large, cells_random, csr_writes);
      $display("%0d results checked against the predicted next generation.", results_checked);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
